// ===== rtl/core/gdn_pkg.sv =====
// ----------------------------------------------------------------------------
// gdn_pkg
// Shared types, constants, calendar tables and the sequencer program for the
// Gregorian day number converter.
// ----------------------------------------------------------------------------
package gdn_pkg;

  localparam int YEAR_W = 14;
  localparam int DAYN_W = 22;
  localparam int PC_W   = 5;
  localparam int QUO_W  = 8;

  // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  typedef enum logic [3:0] {
    TY_HOLD,
    TY_YY_M1,
    TY_YY,
    TY_FIRST_M1,
    TY_LAST,
    TY_MID,
    TY_MID_NXT,
    TY_LO_M1,
    TY_LO
  } ty_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_FWD_DT,
    ACC_FWD_MON,
    ACC_REM,
    ACC_MONTH
  } acc_op_t;

  typedef enum logic [1:0] {
    SRCH_HOLD,
    SRCH_INIT,
    SRCH_STEP
  } srch_op_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_FWD,
    OUT_REV,
    OUT_ERR
  } out_op_t;

  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_OP_REV,
    CND_BAD_DATE,
    CND_BAD_CFG,
    CND_CNT_LE_DT,
    CND_CNT_GT_DT,
    CND_LO_EQ_HI,
    CND_SRCH_NE,
    CND_MONTH_GO
  } cond_t;

  typedef struct packed {
    ty_sel_t          ty_sel;
    acc_op_t          acc_op;
    srch_op_t         srch_op;
    out_op_t          out_op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctl_t;

  // days-through unit result, from its second stage register
  typedef struct packed {
    logic [DAYN_W-1:0] days;
    logic              leap;
  } dt_res_t;

  // program step addresses
  localparam logic [PC_W-1:0] STEP_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH = 5'd1;
  localparam logic [PC_W-1:0] STEP_R_START  = 5'd8;
  localparam logic [PC_W-1:0] STEP_S_HEAD   = 5'd13;
  localparam logic [PC_W-1:0] STEP_S_WAIT   = 5'd14;
  localparam logic [PC_W-1:0] STEP_R_YEAR   = 5'd17;
  localparam logic [PC_W-1:0] STEP_M_LOOP   = 5'd21;
  localparam logic [PC_W-1:0] STEP_ERR      = 5'd23;

  function automatic ctl_t mk(ty_sel_t ty, acc_op_t acc, srch_op_t srch, out_op_t outp,
                              cond_t cnd, logic [PC_W-1:0] tgt);
    ctl_t w;
    w.ty_sel  = ty;
    w.acc_op  = acc;
    w.srch_op = srch;
    w.out_op  = outp;
    w.cond    = cnd;
    w.target  = tgt;
    return w;
  endfunction

  // control store: one word per step
  function automatic ctl_t ucode(logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      // forward: date to day count
      5'd1:    w = mk(TY_YY_M1, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_OP_REV, STEP_R_START);
      5'd2:    w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_BAD_DATE, STEP_ERR);
      5'd3:    w = mk(TY_YY, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd4:    w = mk(TY_HOLD, ACC_FWD_DT, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd5:    w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd6:    w = mk(TY_HOLD, ACC_FWD_MON, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd7:    w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_FWD, CND_ALWAYS, STEP_IDLE);
      // reverse: range check
      5'd8:    w = mk(TY_FIRST_M1, ACC_HOLD, SRCH_INIT, OUT_NONE, CND_BAD_CFG, STEP_ERR);
      5'd9:    w = mk(TY_LAST, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd10:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd11:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_CNT_LE_DT, STEP_ERR);
      5'd12:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_CNT_GT_DT, STEP_ERR);
      // reverse: binary search for the year
      5'd13:   w = mk(TY_MID, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_LO_EQ_HI, STEP_R_YEAR);
      5'd14:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd15:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd16:   w = mk(TY_MID_NXT, ACC_HOLD, SRCH_STEP, OUT_NONE, CND_SRCH_NE, STEP_S_WAIT);
      // reverse: remainder and month walk
      5'd17:   w = mk(TY_LO_M1, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd18:   w = mk(TY_LO, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd19:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd20:   w = mk(TY_HOLD, ACC_REM, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
      5'd21:   w = mk(TY_HOLD, ACC_MONTH, SRCH_HOLD, OUT_NONE, CND_MONTH_GO, STEP_M_LOOP);
      5'd22:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_REV, CND_ALWAYS, STEP_IDLE);
      5'd23:   w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_ERR, CND_ALWAYS, STEP_IDLE);
      default: w = mk(TY_HOLD, ACC_HOLD, SRCH_HOLD, OUT_NONE, CND_NEVER, STEP_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] cum_days(logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/gdn_dtcalc.sv =====
// ----------------------------------------------------------------------------
// gdn_dtcalc
// Two-stage days-through unit: days in years 1..y and the leap flag of y.
// ----------------------------------------------------------------------------
module gdn_dtcalc (
  input  logic                           clk,
  input  logic [gdn_pkg::YEAR_W-1:0]     year_i,
  output gdn_pkg::dt_res_t               res_o
);

  localparam int PROD_W = gdn_pkg::YEAR_W + 13;

  logic [gdn_pkg::DAYN_W-1:0] prod_r;
  logic [gdn_pkg::QUO_W-1:0]  quo_r;
  logic [gdn_pkg::YEAR_W-1:0] yd_r;
  gdn_pkg::dt_res_t           res_r;

  logic [PROD_W-1:0]          prod_full;
  logic [PROD_W-1:0]          recip;
  logic [gdn_pkg::YEAR_W-1:0] hundreds;
  gdn_pkg::dt_res_t           res_nxt;

  always_comb begin
    prod_full = PROD_W'(year_i) * PROD_W'(365);
    recip     = PROD_W'(year_i) * PROD_W'(gdn_pkg::DIV100_MUL);
  end

  // stage 1: y*365 and y/100
  always_ff @(posedge clk) begin
    prod_r <= prod_full[gdn_pkg::DAYN_W-1:0];
    quo_r  <= recip[gdn_pkg::DIV100_SHIFT +: gdn_pkg::QUO_W];
    yd_r   <= year_i;
  end

  // stage 2: y*365 + y/4 - y/100 + y/400, leap by the full rule
  always_comb begin
    hundreds     = gdn_pkg::YEAR_W'(quo_r) * gdn_pkg::YEAR_W'(100);
    res_nxt.days = prod_r + gdn_pkg::DAYN_W'(yd_r >> 2) - gdn_pkg::DAYN_W'(quo_r)
                 + gdn_pkg::DAYN_W'(quo_r >> 2);
    res_nxt.leap = (yd_r[1:0] == 2'd0) && ((yd_r != hundreds) || (quo_r[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

// ===== rtl/core/gregorian_day_number_converter.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_number_converter
// Two-way proleptic Gregorian converter between year/month/day and a day
// count with 0001-01-01 as day 1, run by a microcoded step sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_ready   | operation, year, month, day, count
//  out     | output    | out_valid / out_ready | count, year, month, day, status
//
//  Flow: one word at a time, one step per cycle unless an output step is held,
//  then idle to take the next word. A date-to-count word runs the forward
//  steps to its output step, or the error step when flagged. A count-to-date
//  word over the default 2000..2100 span runs setup and range check (error
//  step for a count outside it), 6 or 7 halvings that each wait on the
//  two-stage days-through unit, the remainder, a step per month walked, the load.
//  Reset: synchronous, active low; clears the step counter and out_valid.
//  Stalls: in_ready is high only while the sequencer is idle. A held result
//  does not block the next word; the sequencer waits at its output step only.
//
module gregorian_day_number_converter #(
  parameter int SEARCH_FIRST_YEAR = 2000,
  parameter int SEARCH_LAST_YEAR  = 2100
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [21:0] in_day_number,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [21:0] out_day_number,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic        out_status
);

  localparam int YW = gdn_pkg::YEAR_W;
  localparam int DW = gdn_pkg::DAYN_W;

  localparam logic [YW-1:0] FIRST_Y    = YW'(SEARCH_FIRST_YEAR);
  localparam logic [YW-1:0] FIRST_Y_M1 = YW'(SEARCH_FIRST_YEAR - 1);
  localparam logic [YW-1:0] LAST_Y     = YW'(SEARCH_LAST_YEAR);
  localparam logic          BAD_CFG    = (SEARCH_FIRST_YEAR > SEARCH_LAST_YEAR);

  // sequencer
  logic [gdn_pkg::PC_W-1:0] pc_r, pc_nxt;
  gdn_pkg::ctl_t            ctl;

  // latched word
  logic          op_r;
  logic [YW-1:0] yy_r;
  logic [3:0]    mm_r;
  logic [4:0]    dd_r;
  logic [DW-1:0] cnt_r;

  // datapath registers
  logic [YW-1:0] ty_r, ty_nxt;
  logic [YW-1:0] lo_r, lo_nxt;
  logic [YW-1:0] hi_r, hi_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [3:0]    mon_r, mon_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] o_dn_r, o_dn_nxt;
  logic [11:0]   o_year_r, o_year_nxt;
  logic [3:0]    o_mon_r, o_mon_nxt;
  logic [4:0]    o_day_r, o_day_nxt;
  logic          o_stat_r, o_stat_nxt;

  gdn_pkg::dt_res_t dt;

  logic          accept;
  logic          out_busy;
  logic          hold;
  logic          cond_hit;
  logic          bad_date;
  logic          dt_ge_cnt;
  logic [YW:0]   mid_sum, mid_nxt_sum;
  logic [YW-1:0] mid, mid_nxt;
  logic [YW-1:0] lo_step, hi_step;
  logic [4:0]    mlen;
  logic          month_done;

  // shared adder
  logic [DW-1:0] add_a, add_b, add_sum;
  logic          add_sub, add_cin;

  gdn_dtcalc u_dtcalc (
    .clk    (clk),
    .year_i (ty_r),
    .res_o  (dt)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (pc_r == gdn_pkg::STEP_IDLE);
  assign out_busy = out_valid_r && !out_ready;
  assign ctl      = gdn_pkg::ucode(pc_r);

  // stall an output step while the previous result is still held
  assign hold = (ctl.out_op != gdn_pkg::OUT_NONE) && out_busy;

  always_comb begin
    bad_date  = (mm_r == 4'd0) || (mm_r > 4'd12) || (dd_r == 5'd0)
              || (yy_r == '0) || (yy_r > gdn_pkg::YEAR_MAX);
    dt_ge_cnt = (dt.days >= cnt_r);

    // search halving; ty_r holds the midpoint at the update step
    mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
    mid         = mid_sum[YW:1];
    lo_step     = dt_ge_cnt ? lo_r : ty_r + YW'(1);
    hi_step     = dt_ge_cnt ? ty_r : hi_r;
    mid_nxt_sum = {1'b0, lo_step} + {1'b0, hi_step};
    mid_nxt     = mid_nxt_sum[YW:1];

    mlen       = gdn_pkg::month_len(mon_r, dt.leap);
    month_done = (acc_r <= DW'(mlen)) || (mon_r >= 4'd12);
  end

  // branch condition
  always_comb begin
    case (ctl.cond)
      gdn_pkg::CND_NEVER:     cond_hit = 1'b0;
      gdn_pkg::CND_ALWAYS:    cond_hit = 1'b1;
      gdn_pkg::CND_OP_REV:    cond_hit = op_r;
      gdn_pkg::CND_BAD_DATE:  cond_hit = bad_date;
      gdn_pkg::CND_BAD_CFG:   cond_hit = BAD_CFG;
      gdn_pkg::CND_CNT_LE_DT: cond_hit = dt_ge_cnt;
      gdn_pkg::CND_CNT_GT_DT: cond_hit = !dt_ge_cnt;
      gdn_pkg::CND_LO_EQ_HI:  cond_hit = (lo_r == hi_r);
      gdn_pkg::CND_SRCH_NE:   cond_hit = (lo_step != hi_step);
      gdn_pkg::CND_MONTH_GO:  cond_hit = !month_done;
      default:                cond_hit = 1'b0;
    endcase
  end

  // step counter: idle waits for a word, output steps wait for the sink
  always_comb begin
    if (pc_r == gdn_pkg::STEP_IDLE) begin
      pc_nxt = accept ? gdn_pkg::STEP_DISPATCH : gdn_pkg::STEP_IDLE;
    end else if (hold) begin
      pc_nxt = pc_r;
    end else if (cond_hit) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = pc_r + gdn_pkg::PC_W'(1);
    end
  end

  // shared adder operand select: a + (b ^ sub) + cin
  always_comb begin
    add_a   = acc_r;
    add_b   = '0;
    add_sub = 1'b0;
    add_cin = 1'b0;
    case (ctl.acc_op)
      gdn_pkg::ACC_FWD_DT: begin
        add_a = dt.days;
        add_b = DW'(dd_r);
      end
      gdn_pkg::ACC_FWD_MON: begin
        add_b   = DW'(gdn_pkg::cum_days(mm_r));
        add_cin = (mm_r > 4'd2) && dt.leap;
      end
      gdn_pkg::ACC_REM: begin
        add_a   = cnt_r;
        add_b   = dt.days;
        add_sub = 1'b1;
        add_cin = 1'b1;
      end
      gdn_pkg::ACC_MONTH: begin
        add_b   = DW'(mlen);
        add_sub = 1'b1;
        add_cin = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_a + (add_b ^ {DW{add_sub}}) + DW'(add_cin);
  end

  // datapath next values
  always_comb begin
    case (ctl.ty_sel)
      gdn_pkg::TY_YY_M1:    ty_nxt = yy_r - YW'(1);
      gdn_pkg::TY_YY:       ty_nxt = yy_r;
      gdn_pkg::TY_FIRST_M1: ty_nxt = FIRST_Y_M1;
      gdn_pkg::TY_LAST:     ty_nxt = LAST_Y;
      gdn_pkg::TY_MID:      ty_nxt = mid;
      gdn_pkg::TY_MID_NXT:  ty_nxt = mid_nxt;
      gdn_pkg::TY_LO_M1:    ty_nxt = lo_r - YW'(1);
      gdn_pkg::TY_LO:       ty_nxt = lo_r;
      default:              ty_nxt = ty_r;
    endcase

    case (ctl.srch_op)
      gdn_pkg::SRCH_INIT: begin
        lo_nxt = FIRST_Y;
        hi_nxt = LAST_Y;
      end
      gdn_pkg::SRCH_STEP: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
      end
      default: begin
        lo_nxt = lo_r;
        hi_nxt = hi_r;
      end
    endcase

    acc_nxt = acc_r;
    mon_nxt = mon_r;
    case (ctl.acc_op)
      gdn_pkg::ACC_FWD_DT, gdn_pkg::ACC_FWD_MON: begin
        acc_nxt = add_sum;
      end
      gdn_pkg::ACC_REM: begin
        acc_nxt = add_sum;
        mon_nxt = 4'd1;
      end
      gdn_pkg::ACC_MONTH: begin
        // advance a month only while the remainder overruns it and the month is below 12
        if (!month_done) begin
          acc_nxt = add_sum;
          mon_nxt = mon_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: load on an output step, drop valid when taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    o_dn_nxt      = o_dn_r;
    o_year_nxt    = o_year_r;
    o_mon_nxt     = o_mon_r;
    o_day_nxt     = o_day_r;
    o_stat_nxt    = o_stat_r;
    if (!hold) begin
      case (ctl.out_op)
        gdn_pkg::OUT_FWD: begin
          out_valid_nxt = 1'b1;
          o_dn_nxt      = acc_r;
          o_year_nxt    = '0;
          o_mon_nxt     = '0;
          o_day_nxt     = '0;
          o_stat_nxt    = 1'b0;
        end
        gdn_pkg::OUT_REV: begin
          out_valid_nxt = 1'b1;
          o_dn_nxt      = '0;
          o_year_nxt    = lo_r[11:0];
          o_mon_nxt     = mon_r;
          o_day_nxt     = acc_r[4:0];
          o_stat_nxt    = 1'b0;
        end
        gdn_pkg::OUT_ERR: begin
          out_valid_nxt = 1'b1;
          o_dn_nxt      = '0;
          o_year_nxt    = '0;
          o_mon_nxt     = '0;
          o_day_nxt     = '0;
          o_stat_nxt    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= gdn_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      yy_r  <= in_year;
      mm_r  <= in_month;
      dd_r  <= in_day;
      cnt_r <= in_day_number;
    end
    ty_r     <= ty_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    acc_r    <= acc_nxt;
    mon_r    <= mon_nxt;
    o_dn_r   <= o_dn_nxt;
    o_year_r <= o_year_nxt;
    o_mon_r  <= o_mon_nxt;
    o_day_r  <= o_day_nxt;
    o_stat_r <= o_stat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_day_number = o_dn_r;
  assign out_year       = o_year_r;
  assign out_month      = o_mon_r;
  assign out_day        = o_day_r;
  assign out_status     = o_stat_r;

endmodule

// ===== rtl/core/gdn_checker.sv =====
// ----------------------------------------------------------------------------
// gdn_checker
// Port-level checks for the Gregorian day number converter, bound to the top.
// ----------------------------------------------------------------------------
module gdn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [21:0] out_day_number,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic        out_status
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_day_number) && $stable(out_year)
      && $stable(out_month) && $stable(out_day) && $stable(out_status))
    else $error("result changed while stalled");

  // one word in flight: input closes right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // error results carry all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_day_number == 22'd0 && out_year == 12'd0
      && out_month == 4'd0 && out_day == 5'd0)
    else $error("error result with nonzero fields");

  // a good result is either a count or a date, never both or neither
  a_good_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> (out_day_number != 22'd0) != (out_month != 4'd0))
    else $error("good result has no single kind");

  // a good date has a month of at most 12 and a nonzero day
  a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status && out_day_number == 22'd0 |->
      out_month <= 4'd12 && out_day != 5'd0)
    else $error("good date out of range");

endmodule

bind gregorian_day_number_converter gdn_checker u_gdn_checker (.*);

// ===== dv/date_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_result_checker
// Watches both channels of the day number converter, works out the expected
// result word of every accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module date_result_checker #(
  parameter int FIRST_YEAR = 2000,
  parameter int LAST_YEAR  = 2100
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [21:0] in_day_number,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [21:0] out_day_number,
  input  logic [11:0] out_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day,
  input  logic        out_status,

  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [21:0] day_number;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        status;
  } date_word_t;

  date_word_t expected_words[$];
  date_word_t oldest;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // days in years 1..y
  function automatic int unsigned days_to_end_of(int unsigned y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic int unsigned month_days(int unsigned m, bit leap);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic date_word_t convert(bit op, logic [13:0] y, logic [3:0] m,
                                         logic [4:0] d, logic [21:0] n);
    date_word_t  r;
    int unsigned total;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned rem;
    int unsigned mth;
    r = '0;
    if (!op) begin
      if (m < 1 || m > 12 || d == 0 || y < 1 || y > 9999) begin
        r.status = 1'b1;
      end else begin
        total = d;
        for (int unsigned i = 1; i < m; i++) total += month_days(i, 1'b0);
        if (m > 2 && leap_year(y)) total += 1;
        total += days_to_end_of(y - 1);
        r.day_number = total[21:0];
      end
    end else begin
      if (FIRST_YEAR > LAST_YEAR || n <= days_to_end_of(FIRST_YEAR - 1) ||
          n > days_to_end_of(LAST_YEAR)) begin
        r.status = 1'b1;
      end else begin
        lo = FIRST_YEAR;
        hi = LAST_YEAR;
        while (lo != hi) begin
          mid = (lo + hi) >> 1;
          if (days_to_end_of(mid) >= n) hi = mid;
          else lo = mid + 1;
        end
        rem = n - days_to_end_of(lo - 1);
        mth = 1;
        while (rem > month_days(mth, leap_year(lo)) && mth < 12) begin
          rem -= month_days(mth, leap_year(lo));
          mth++;
        end
        r.year  = lo[11:0];
        r.month = mth[3:0];
        r.day   = rem[4:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches = mismatches + 1;
    end
  endtask

  // retire results before queuing new words so that a same-edge pair never
  // matches a result against its own input
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0d %0d-%0d-%0d st %0b",
                   $time, out_day_number, out_year, out_month, out_day, out_status);
          mismatches = mismatches + 1;
        end else begin
          oldest = expected_words.pop_front();
          check_field("day_number", oldest.day_number, out_day_number);
          check_field("year", oldest.year, out_year);
          check_field("month", oldest.month, out_month);
          check_field("day", oldest.day, out_day);
          check_field("status", oldest.status, out_status);
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(convert(in_operation, in_year, in_month, in_day,
                                         in_day_number));
      outstanding = expected_words.size();
    end
  end

endmodule

// ===== dv/tb_gregorian_day_number_converter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_day_number_converter
// Drives date and day count words into the converter with random idling on
// both channels; a side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_gregorian_day_number_converter;

  localparam int FIRST_YEAR     = 2000;
  localparam int LAST_YEAR      = 2100;
  // day numbers of 2000-01-01 and 2100-12-31, the ends of the searched span
  localparam int FIRST_DAY      = 730120;
  localparam int LAST_DAY       = 767009;
  localparam int RANDOM_WORDS   = 1950;
  localparam int QUIET_WORDS    = 200;
  localparam int HOLD_OFF_LEN   = 500;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam bit OP_TO_COUNT    = 1'b0;
  localparam bit OP_TO_DATE     = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [21:0] in_day_number;
  logic        out_valid;
  logic        out_ready;
  logic [21:0] out_day_number;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        out_status;

  int mismatches;
  int outstanding;
  int cycle_count;
  int gap_odds;
  bit quiet;
  bit hold_off_req;

  gregorian_day_number_converter #(
    .SEARCH_FIRST_YEAR (FIRST_YEAR),
    .SEARCH_LAST_YEAR  (LAST_YEAR)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_day_number  (in_day_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_day_number (out_day_number),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_status     (out_status)
  );

  date_result_checker #(
    .FIRST_YEAR (FIRST_YEAR),
    .LAST_YEAR  (LAST_YEAR)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_day_number  (in_day_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_day_number (out_day_number),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_status     (out_status),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort the run if the converter hangs or stalls forever.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** gregorian_day_number_converter: FAILED **");
      $finish;
    end
  end

  // Result side: drop out_ready in random bursts, with the burst rate redrawn
  // span by span so that some stretches never stall. A hold-off request from
  // the stimulus side closes the channel for a long stretch so the held result
  // backs up into in_ready.
  initial begin
    int hold_left;
    int stall_odds;
    int span;
    hold_left  = 0;
    stall_odds = 0;
    span       = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        stall_odds = $urandom_range(0, 3) * 8;
        span = 128;
      end
      span = span - 1;
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_LEN;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready = 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 99) < stall_odds) begin
        hold_left = $urandom_range(0, 17);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one word at the falling edge, hold it until the rising edge that
  // takes it, then return at the next falling edge with in_valid still high
  // so back-to-back words need no drop.
  task automatic send_word(bit op, logic [13:0] y, logic [3:0] m, logic [4:0] d,
                           logic [21:0] n);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_odds) begin
      gap = $urandom_range(1, 18);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation  = op;
    in_year       = y;
    in_month      = m;
    in_day        = d;
    in_day_number = n;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Unused fields of each word carry random bits; the block must ignore them.
  task automatic offer_date(logic [13:0] y, logic [3:0] m, logic [4:0] d);
    send_word(OP_TO_COUNT, y, m, d, 22'($urandom()));
  endtask

  task automatic offer_count(logic [21:0] n);
    send_word(OP_TO_DATE, 14'($urandom()), 4'($urandom()), 5'($urandom()), n);
  endtask

  task automatic offer_random_date();
    int          kind;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    kind = $urandom_range(0, 19);
    y = (kind < 5) ? 14'($urandom_range(FIRST_YEAR - 1, LAST_YEAR + 1))
                   : 14'($urandom_range(1, 9999));
    m = 4'($urandom_range(1, 12));
    d = 5'($urandom_range(1, 31));
    // break exactly one field of an otherwise good date
    if (kind == 15) m = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
    if (kind == 16) d = 5'd0;
    if (kind == 17) y = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'($urandom_range(10000, 16383));
    if (kind >= 18) begin
      y = 14'($urandom());
      m = 4'($urandom());
      d = 5'($urandom());
    end
    offer_date(y, m, d);
  endtask

  task automatic offer_random_count();
    int          kind;
    logic [21:0] n;
    kind = $urandom_range(0, 9);
    if (kind < 7)       n = 22'($urandom_range(FIRST_DAY, LAST_DAY));
    else if (kind == 7) n = ($urandom_range(0, 1) == 0) ?
                            22'($urandom_range(FIRST_DAY - 3, FIRST_DAY + 3)) :
                            22'($urandom_range(LAST_DAY - 3, LAST_DAY + 3));
    else if (kind == 8) n = 22'($urandom_range(0, FIRST_DAY - 1));
    else                n = 22'($urandom());
    offer_count(n);
  endtask

  // Hold the sender until every queued result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = 1'b0;
    in_year       = '0;
    in_month      = '0;
    in_day        = '0;
    in_day_number = '0;
    quiet         = 1'b0;
    hold_off_req  = 1'b0;
    gap_odds      = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: first and last representable dates, leap days and century
    // years, a day beyond the month end, every flagged date field, then the
    // ends of the searched span and counts just outside it.
    offer_date(14'd1, 4'd1, 5'd1);
    offer_date(14'd9999, 4'd12, 5'd31);
    offer_date(14'd2000, 4'd2, 5'd29);
    offer_date(14'd2000, 4'd3, 5'd1);
    offer_date(14'd1900, 4'd3, 5'd1);
    offer_date(14'd2100, 4'd3, 5'd1);
    offer_date(14'd2024, 4'd12, 5'd31);
    offer_date(14'd2023, 4'd2, 5'd31);
    offer_date(14'd2024, 4'd0, 5'd15);
    offer_date(14'd2024, 4'd13, 5'd1);
    offer_date(14'd2024, 4'd15, 5'd31);
    offer_date(14'd2024, 4'd6, 5'd0);
    offer_date(14'd0, 4'd1, 5'd1);
    offer_date(14'd10000, 4'd1, 5'd1);
    offer_date(14'd16383, 4'd15, 5'd31);
    offer_count(22'd0);
    offer_count(22'(FIRST_DAY - 1));
    offer_count(22'(FIRST_DAY));
    offer_count(22'(FIRST_DAY + 59));
    offer_count(22'(FIRST_DAY + 366 + 58));
    offer_count(22'(LAST_DAY - 30));
    offer_count(22'(LAST_DAY));
    offer_count(22'(LAST_DAY + 1));
    offer_count(22'h3FFFFF);
    drain();

    // Random: half dates, half counts; sender gap rate redrawn every 64 words.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) gap_odds = $urandom_range(0, 3) * 10;
      // close the result channel for a long stretch while words keep coming
      if (i == 400) hold_off_req = 1'b1;
      if (i == 900 || i == 1500) drain();
      if (i == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      if ($urandom_range(0, 1) == 0) offer_random_date();
      else offer_random_count();
    end

    drain();
    repeat (64) @(negedge clk);
    if (mismatches == 0) begin
      $display("** gregorian_day_number_converter: PASSED **");
    end else begin
      $display("** gregorian_day_number_converter: FAILED **");
    end
    $finish;
  end

endmodule
